[sv/vp9rtp_pkg.sv]
// ----------------------------------------------------------------------------
// vp9rtp_pkg
// shared types, phase codes, result kinds and limits of the vp9 rtp
// payload descriptor parser
// ----------------------------------------------------------------------------
package vp9rtp_pkg;

    // limits of the descriptor
    localparam int MAX_SPATIAL_LAYERS = 5;
    localparam int MAX_REF_PICS       = 3;

    // parse phases
    localparam logic [3:0] PH_FLAGS   = 4'd0;
    localparam logic [3:0] PH_PICID1  = 4'd1;
    localparam logic [3:0] PH_PICID2  = 4'd2;
    localparam logic [3:0] PH_LAYER   = 4'd3;
    localparam logic [3:0] PH_TL0     = 4'd4;
    localparam logic [3:0] PH_PDIFF   = 4'd5;
    localparam logic [3:0] PH_SS      = 4'd6;
    localparam logic [3:0] PH_WH      = 4'd7;
    localparam logic [3:0] PH_NG      = 4'd8;
    localparam logic [3:0] PH_GROUP   = 4'd9;
    localparam logic [3:0] PH_GPDIFF  = 4'd10;
    localparam logic [3:0] PH_PAYLOAD = 4'd11;
    localparam logic [3:0] PH_DRAIN   = 4'd12;

    // result kinds
    localparam logic [3:0] KIND_NONE    = 4'd0;
    localparam logic [3:0] KIND_FLAGS   = 4'd1;
    localparam logic [3:0] KIND_PICID   = 4'd2;
    localparam logic [3:0] KIND_LAYER   = 4'd3;
    localparam logic [3:0] KIND_TL0     = 4'd4;
    localparam logic [3:0] KIND_PDIFF   = 4'd5;
    localparam logic [3:0] KIND_SS      = 4'd6;
    localparam logic [3:0] KIND_WIDTH   = 4'd7;
    localparam logic [3:0] KIND_HEIGHT  = 4'd8;
    localparam logic [3:0] KIND_NG      = 4'd9;
    localparam logic [3:0] KIND_GROUP   = 4'd10;
    localparam logic [3:0] KIND_GPDIFF  = 4'd11;
    localparam logic [3:0] KIND_PAYLOAD = 4'd12;

    // packet status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_SHORT       = 2'd1;
    localparam logic [1:0] ST_TOO_MANY_SL = 2'd2;
    localparam logic [1:0] ST_TOO_MANY_PD = 2'd3;

    // descriptor flag bits
    localparam int FLAG_I = 7;
    localparam int FLAG_P = 6;
    localparam int FLAG_L = 5;
    localparam int FLAG_F = 4;
    localparam int FLAG_V = 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] value;
        logic [7:0]  entry_index;
        logic [1:0]  sub_index;
        logic [1:0]  status;
        logic        packet_end;
    } result_t;

    // first enabled descriptor stage at or after stage s
    function automatic logic [3:0] next_stage(input logic [7:0] f, input logic [3:0] s);
        if (s <= PH_PICID1 && f[FLAG_I]) return PH_PICID1;
        if (s <= PH_LAYER && f[FLAG_L]) return PH_LAYER;
        if (s <= PH_TL0 && f[FLAG_L] && !f[FLAG_F]) return PH_TL0;
        if (s <= PH_PDIFF && f[FLAG_F] && f[FLAG_P]) return PH_PDIFF;
        if (s <= PH_SS && f[FLAG_V]) return PH_SS;
        return PH_PAYLOAD;
    endfunction

endpackage

[sv/vp9rtp_byte_if.sv]
// ----------------------------------------------------------------------------
// vp9rtp_byte_if
// input channel: one payload byte per word with an end-of-packet mark
// ----------------------------------------------------------------------------
interface vp9rtp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[sv/vp9rtp_result_if.sv]
// ----------------------------------------------------------------------------
// vp9rtp_result_if
// output channel: one decoded field per word
// ----------------------------------------------------------------------------
interface vp9rtp_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [15:0] value;
    logic [7:0]  entry_index;
    logic [1:0]  sub_index;
    logic [1:0]  status;
    logic        packet_end;

    modport source (output valid, output kind, output value, output entry_index,
                    output sub_index, output status, output packet_end, input ready);
    modport sink   (input valid, input kind, input value, input entry_index,
                    input sub_index, input status, input packet_end, output ready);
endinterface

[sv/vp9rtp_in_stage.sv]
// ----------------------------------------------------------------------------
// vp9rtp_in_stage
// input register; refills in the same cycle the held word moves on
// ----------------------------------------------------------------------------
module vp9rtp_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    vp9rtp_byte_if.sink         rx,
    input  logic                take,
    output logic                word_valid,
    output vp9rtp_pkg::in_word_t word
);
    import vp9rtp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign rx.ready   = !valid_reg || take;
    assign valid_next = (rx.valid && rx.ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            word_reg <= '{data_byte: rx.data_byte, last_byte: rx.last_byte};
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;
endmodule

[sv/vp9rtp_parse.sv]
// ----------------------------------------------------------------------------
// vp9rtp_parse
// descriptor phase machine: decodes one byte into one result per step
// ----------------------------------------------------------------------------
module vp9rtp_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  vp9rtp_pkg::in_word_t  word,
    output vp9rtp_pkg::result_t   result
);
    import vp9rtp_pkg::*;

    logic [3:0] phase_reg,        phase_next;
    logic [7:0] flags_reg,        flags_next;
    logic [7:0] held_reg,         held_next;
    logic [1:0] bif_reg,          bif_next;
    logic [1:0] pdiff_count_reg,  pdiff_count_next;
    logic [3:0] layers_left_reg,  layers_left_next;
    logic [2:0] layer_number_reg, layer_number_next;
    logic [1:0] ss_flags_reg,     ss_flags_next;
    logic [7:0] groups_left_reg,  groups_left_next;
    logic [7:0] group_number_reg, group_number_next;
    logic [1:0] refs_left_reg,    refs_left_next;
    logic [1:0] error_reg,        error_next;

    logic [7:0] b;
    logic [2:0] seen;
    logic [3:0] layers_dec;
    logic [7:0] groups_dec;
    logic [1:0] refs_dec;
    logic [3:0] after_sizes;
    logic [3:0] after_group;

    assign b           = word.data_byte;
    assign seen        = {1'b0, pdiff_count_reg} + 3'd1;
    assign layers_dec  = layers_left_reg - 4'd1;
    assign groups_dec  = groups_left_reg - 8'd1;
    assign refs_dec    = refs_left_reg - 2'd1;
    assign after_sizes = ss_flags_reg[0] ? PH_NG : PH_PAYLOAD;
    assign after_group = (groups_dec == 8'd0) ? PH_PAYLOAD : PH_GROUP;

    always_comb
    begin
        phase_next        = phase_reg;
        flags_next        = flags_reg;
        held_next         = held_reg;
        bif_next          = bif_reg;
        pdiff_count_next  = pdiff_count_reg;
        layers_left_next  = layers_left_reg;
        layer_number_next = layer_number_reg;
        ss_flags_next     = ss_flags_reg;
        groups_left_next  = groups_left_reg;
        group_number_next = group_number_reg;
        refs_left_next    = refs_left_reg;
        error_next        = error_reg;
        result            = '0;

        case (phase_reg)
            PH_FLAGS:
            begin
                flags_next   = b;
                result.kind  = KIND_FLAGS;
                result.value = {8'd0, b};
                phase_next   = next_stage(b, PH_PICID1);
            end
            PH_PICID1:
            begin
                if (b[7])
                begin
                    held_next  = {1'b0, b[6:0]};
                    phase_next = PH_PICID2;
                end
                else
                begin
                    result.kind  = KIND_PICID;
                    result.value = {9'd0, b[6:0]};
                    phase_next   = next_stage(flags_reg, PH_LAYER);
                end
            end
            PH_PICID2:
            begin
                result.kind  = KIND_PICID;
                result.value = {held_reg, b};
                phase_next   = next_stage(flags_reg, PH_LAYER);
            end
            PH_LAYER:
            begin
                // spatial id beyond the supported layer count
                if ({1'b0, b[3:1]} >= 4'(MAX_SPATIAL_LAYERS))
                begin
                    error_next = ST_TOO_MANY_SL;
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    result.kind  = KIND_LAYER;
                    result.value = {8'd0, b};
                    phase_next   = next_stage(flags_reg, PH_TL0);
                end
            end
            PH_TL0:
            begin
                result.kind  = KIND_TL0;
                result.value = {8'd0, b};
                phase_next   = next_stage(flags_reg, PH_PDIFF);
            end
            PH_PDIFF:
            begin
                if (!b[0])
                begin
                    result.kind        = KIND_PDIFF;
                    result.value       = {9'd0, b[7:1]};
                    result.entry_index = {6'd0, pdiff_count_reg};
                    phase_next         = next_stage(flags_reg, PH_SS);
                end
                else if (seen >= 3'(MAX_REF_PICS))
                begin
                    error_next = ST_TOO_MANY_PD;
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    result.kind        = KIND_PDIFF;
                    result.value       = {9'd0, b[7:1]};
                    result.entry_index = {6'd0, pdiff_count_reg};
                    pdiff_count_next   = seen[1:0];
                end
            end
            PH_SS:
            begin
                result.kind   = KIND_SS;
                result.value  = {11'd0, b[7:3]};
                ss_flags_next = b[4:3];
                if (b[4])
                begin
                    layers_left_next  = {1'b0, b[7:5]} + 4'd1;
                    layer_number_next = 3'd0;
                    bif_next          = 2'd0;
                    phase_next        = PH_WH;
                end
                else
                begin
                    phase_next = b[3] ? PH_NG : PH_PAYLOAD;
                end
            end
            PH_WH:
            begin
                // high byte then low byte of width, then of height
                if (!bif_reg[0])
                begin
                    held_next = b;
                end
                else
                begin
                    result.kind        = (bif_reg == 2'd1) ? KIND_WIDTH : KIND_HEIGHT;
                    result.value       = {held_reg, b};
                    result.entry_index = {5'd0, layer_number_reg};
                end
                if (bif_reg == 2'd3)
                begin
                    bif_next          = 2'd0;
                    layer_number_next = layer_number_reg + 3'd1;
                    layers_left_next  = layers_dec;
                    if (layers_dec == 4'd0)
                    begin
                        phase_next = after_sizes;
                    end
                end
                else
                begin
                    bif_next = bif_reg + 2'd1;
                end
            end
            PH_NG:
            begin
                result.kind       = KIND_NG;
                result.value      = {8'd0, b};
                groups_left_next  = b;
                group_number_next = 8'd0;
                phase_next        = (b == 8'd0) ? PH_PAYLOAD : PH_GROUP;
            end
            PH_GROUP:
            begin
                result.kind        = KIND_GROUP;
                result.value       = {10'd0, b[7:2]};
                result.entry_index = group_number_reg;
                refs_left_next     = b[3:2];
                bif_next           = 2'd0;
                if (b[3:2] != 2'd0)
                begin
                    phase_next = PH_GPDIFF;
                end
                else
                begin
                    group_number_next = group_number_reg + 8'd1;
                    groups_left_next  = groups_dec;
                    phase_next        = after_group;
                end
            end
            PH_GPDIFF:
            begin
                result.kind        = KIND_GPDIFF;
                result.value       = {8'd0, b};
                result.entry_index = group_number_reg;
                result.sub_index   = bif_reg;
                bif_next           = bif_reg + 2'd1;
                refs_left_next     = refs_dec;
                if (refs_dec == 2'd0)
                begin
                    group_number_next = group_number_reg + 8'd1;
                    groups_left_next  = groups_dec;
                    phase_next        = after_group;
                end
            end
            PH_PAYLOAD:
            begin
                result.kind  = KIND_PAYLOAD;
                result.value = {8'd0, b};
            end
            default:
            begin
                phase_next = PH_DRAIN;
            end
        endcase

        // end of packet: report status and start over at a flag byte
        if (word.last_byte)
        begin
            result.packet_end = 1'b1;
            if (error_next != ST_OK)
            begin
                result.status = error_next;
            end
            else
            begin
                result.status = (phase_next == PH_PAYLOAD) ? ST_OK : ST_SHORT;
            end
            phase_next        = PH_FLAGS;
            flags_next        = 8'd0;
            held_next         = 8'd0;
            bif_next          = 2'd0;
            pdiff_count_next  = 2'd0;
            layers_left_next  = 4'd0;
            layer_number_next = 3'd0;
            ss_flags_next     = 2'd0;
            groups_left_next  = 8'd0;
            group_number_next = 8'd0;
            refs_left_next    = 2'd0;
            error_next        = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FLAGS;
            flags_reg        <= 8'd0;
            held_reg         <= 8'd0;
            bif_reg          <= 2'd0;
            pdiff_count_reg  <= 2'd0;
            layers_left_reg  <= 4'd0;
            layer_number_reg <= 3'd0;
            ss_flags_reg     <= 2'd0;
            groups_left_reg  <= 8'd0;
            group_number_reg <= 8'd0;
            refs_left_reg    <= 2'd0;
            error_reg        <= ST_OK;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            flags_reg        <= flags_next;
            held_reg         <= held_next;
            bif_reg          <= bif_next;
            pdiff_count_reg  <= pdiff_count_next;
            layers_left_reg  <= layers_left_next;
            layer_number_reg <= layer_number_next;
            ss_flags_reg     <= ss_flags_next;
            groups_left_reg  <= groups_left_next;
            group_number_reg <= group_number_next;
            refs_left_reg    <= refs_left_next;
            error_reg        <= error_next;
        end
    end
endmodule

[sv/vp9rtp_out_stage.sv]
// ----------------------------------------------------------------------------
// vp9rtp_out_stage
// result register toward the receiver
// ----------------------------------------------------------------------------
module vp9rtp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  vp9rtp_pkg::result_t  result,
    output logic                 can_load,
    vp9rtp_result_if.source      tx
);
    import vp9rtp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || tx.ready;
    assign valid_next = load || (valid_reg && !tx.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign tx.valid       = valid_reg;
    assign tx.kind        = result_reg.kind;
    assign tx.value       = result_reg.value;
    assign tx.entry_index = result_reg.entry_index;
    assign tx.sub_index   = result_reg.sub_index;
    assign tx.status      = result_reg.status;
    assign tx.packet_end  = result_reg.packet_end;
endmodule

[sv/vp9rtp_descriptor_parser_core.sv]
// ----------------------------------------------------------------------------
// vp9_rtp_descriptor_parser_core
// vp9 rtp payload descriptor and scalability structure parser, one byte a word
// ----------------------------------------------------------------------------
// usage
//   rx carries the payload bytes of one rtp vp9 packet after another; the
//   word with last_byte set closes a packet and the next word is read as a
//   new descriptor flag byte
//   tx gives exactly one result word per input word, in order, tagged by
//   kind; kind none marks bytes that produce no field (first half of a
//   two-byte field, the byte that raises an error and the bytes after it)
//   on the packet_end word the status reports ok, short packet, too many
//   spatial layers or too many p_diffs; after an error the receiver drops
//   the fields already delivered for that packet
// timing
//   one word per cycle sustained while tx takes every result; a word taken
//   from rx is held in the input register, is decoded by the phase machine
//   and then lands in the result register, which drives tx
//   when tx stalls the result register holds, the input register fills
//   once more and rx.ready then drops until tx takes the result
// reset
//   rst_n clears both stage valids and returns the phase machine to the
//   flag byte phase with all counters at zero
// ----------------------------------------------------------------------------
module vp9_rtp_descriptor_parser_core (
    input  logic            clk,
    input  logic            rst_n,
    vp9rtp_byte_if.sink     rx,
    vp9rtp_result_if.source tx
);
    import vp9rtp_pkg::*;

    // handshake between the stages
    logic     word_valid;
    in_word_t word;
    logic     can_load;
    logic     fire;
    result_t  result;

    // a held word is decoded and moves into the result register together
    assign fire = word_valid && can_load;

    vp9rtp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (fire),
        .word_valid (word_valid),
        .word       (word)
    );

    // phase machine state advances only on a decoded word
    vp9rtp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (word),
        .result (result)
    );

    vp9rtp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (result),
        .can_load (can_load),
        .tx       (tx)
    );
endmodule
